/* rtl/core/dcc_pkg.sv */
// Shared types and codes for the Dragon coherence controller.
// Used by dcc_ctrl, dcc_datapath and the top level; depends on nothing.
package dcc_pkg;

  // Default table depth, width of the block index field
  localparam int DCC_NUM_BLOCKS = 1024;
  localparam int BLK_W          = 10;

  // Event kinds on the input channel
  typedef enum logic [1:0] {
    MODE_CORE  = 2'd0,
    MODE_RESP  = 2'd1,
    MODE_SNOOP = 2'd2,
    MODE_EVICT = 2'd3
  } mode_t;

  // Bus transaction type of a response or snoop
  typedef enum logic {
    BUS_RD  = 1'b0,
    BUS_UPD = 1'b1
  } bus_kind_t;

  // Coherence state of one line
  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_E  = 3'd1,
    ST_SC = 3'd2,
    ST_SM = 3'd3,
    ST_M  = 3'd4
  } line_state_t;

  // Bus request issued
  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_RD   = 2'd1,
    REQ_UPD  = 2'd2
  } bus_req_t;

  // Data array action
  typedef enum logic [1:0] {
    DATA_NONE  = 2'd0,
    DATA_READ  = 2'd1,
    DATA_WRITE = 2'd2
  } data_act_t;

  // Access class for statistics
  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_PRIVATE = 2'd1,
    CLS_SHARED  = 2'd2
  } access_cls_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;   // write invalid at the clear pointer, advance it
    logic load_in;  // capture the input transfer
    logic calc_q;   // register the index quotient
    logic calc_r;   // register the reduced index
    logic rd;       // read the state table
    logic commit;   // write the new state, load the result register
  } dcc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;  // clear pointer at the last entry
    logic out_free;  // result register can take a new result
  } dcc_status_t;

endpackage

/* rtl/core/dcc_ctrl.sv */
// Sequencer of the Dragon coherence controller: clearing pass, then one event at a time.
// Depends on dcc_pkg; drives the command struct of dcc_datapath.
module dcc_ctrl import dcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  dcc_status_t status,
  output dcc_cmd_t    cmd,
  output logic        in_stall
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_QUOT   = 6'b000100,
    S_REM    = 6'b001000,
    S_READ   = 6'b010000,
    S_UPDATE = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        // take the transfer and start working it
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_QUOT;
      end
      S_QUOT: begin
        cmd.calc_q = 1'b1;
        state_next = S_REM;
      end
      S_REM: begin
        cmd.calc_r = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/dcc_datapath.sv */
// Datapath of the Dragon coherence controller: index reduction, state table,
// protocol decision and result register. Depends on dcc_pkg.
module dcc_datapath import dcc_pkg::*; #(
  parameter int NUM_BLOCKS = DCC_NUM_BLOCKS
) (
  input  logic              clk,
  input  logic              rst,
  input  dcc_cmd_t          cmd,
  output dcc_status_t       status,
  input  logic [1:0]        mode,
  input  logic [BLK_W-1:0]  block_index,
  input  logic              is_store,
  input  logic              bus_kind,
  input  logic              shared_seen,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              done_res,
  output logic [1:0]        bus_request,
  output logic              snoop_reply,
  output logic [1:0]        data_action,
  output logic              allocate,
  output logic              release_res,
  output logic              clear_dirty,
  output logic              writeback,
  output logic [2:0]        line_state_out,
  output logic              error,
  output logic [1:0]        access_class,
  output logic              miss
);

  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  // Quotient by multiplication with a scaled reciprocal; exact for a 10-bit index when NUM_BLOCKS is above 8
  localparam int SHIFT   = 2 * BLK_W;
  localparam int RECIP_W = SHIFT - 3;
  localparam int PROD_W  = BLK_W + RECIP_W;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam bit DIRECT  = (NUM_BLOCKS >= (2 ** BLK_W));
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** SHIFT) + NUM_BLOCKS - 1) / NUM_BLOCKS);
  localparam logic [BLK_W-1:0] NUM_LOW = BLK_W'(NUM_BLOCKS);

  // Captured event
  mode_t            mode_r;
  logic [BLK_W-1:0] blk_r;
  logic             store_r;
  logic             upd_r;
  logic             shared_r;

  // Index reduction
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot;
  logic [BLK_W-1:0]  rem_next;
  logic [IDX_W-1:0]  idx;

  // State table
  logic [2:0]       mem [NUM_BLOCKS];
  logic [2:0]       rd_data;
  logic [IDX_W-1:0] clr_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [2:0]       wr_data;

  // Decision
  line_state_t s;
  line_state_t ns;
  logic        done_next;
  bus_req_t    bus_next;
  logic        snoop_next;
  data_act_t   data_next;
  logic        alloc_next;
  logic        rel_next;
  logic        clr_next;
  logic        wb_next;
  logic        err_next;
  access_cls_t cls_next;
  logic        miss_next;

  assign status.clr_last = (clr_idx == IDX_W'(NUM_BLOCKS - 1));
  assign status.out_free = !out_valid || !out_stall;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= mode_t'(mode);
      blk_r    <= block_index;
      store_r  <= is_store;
      upd_r    <= (bus_kind == BUS_UPD);
      shared_r <= shared_seen;
    end
  end

  // Quotient of the index by the table depth
  assign prod = PROD_W'(blk_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.calc_q) quot <= DIRECT ? '0 : prod[PROD_W-1:SHIFT];
  end

  // Remainder: index modulo depth
  assign rem_next = blk_r - BLK_W'(BLK_W'(quot) * NUM_LOW);

  always_ff @(posedge clk) begin
    if (cmd.calc_r) idx <= IDX_W'(rem_next);
  end

  // Clear pointer for the pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_wr && !status.clr_last) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Table write port: clearing pass or new state
  assign wr_en   = cmd.clr_wr || cmd.commit;
  assign wr_addr = cmd.clr_wr ? clr_idx : idx;
  assign wr_data = cmd.clr_wr ? ST_I : ns;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Table read port
  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data <= mem[idx];
  end

  // Protocol decision
  always_comb begin
    case (rd_data)
      ST_E:    s = ST_E;
      ST_SC:   s = ST_SC;
      ST_SM:   s = ST_SM;
      ST_M:    s = ST_M;
      default: s = ST_I;
    endcase
    ns         = s;
    done_next  = 1'b0;
    bus_next   = REQ_NONE;
    snoop_next = 1'b0;
    data_next  = DATA_NONE;
    alloc_next = 1'b0;
    rel_next   = 1'b0;
    clr_next   = 1'b0;
    wb_next    = 1'b0;
    err_next   = 1'b0;
    cls_next   = CLS_NONE;
    miss_next  = 1'b0;
    case (mode_r)
      MODE_CORE: begin
        if (s == ST_I) begin
          bus_next  = REQ_RD;
          miss_next = 1'b1;
        end else if (s inside {ST_SC, ST_SM}) begin
          if (store_r) begin
            bus_next = REQ_UPD;
          end else begin
            data_next = DATA_READ;
            cls_next  = CLS_SHARED;
            done_next = 1'b1;
          end
        end else begin
          data_next = store_r ? DATA_WRITE : DATA_READ;
          cls_next  = CLS_PRIVATE;
          done_next = 1'b1;
          if (store_r) ns = ST_M;
        end
      end
      MODE_RESP: begin
        if (s == ST_I && !upd_r) begin
          alloc_next = 1'b1;
          if (!store_r) begin
            ns        = shared_r ? ST_SC : ST_E;
            data_next = DATA_READ;
            cls_next  = shared_r ? CLS_SHARED : CLS_PRIVATE;
            done_next = 1'b1;
          end else if (shared_r) begin
            ns        = ST_SC;
            data_next = DATA_READ;
            bus_next  = REQ_UPD;
          end else begin
            ns        = ST_M;
            data_next = DATA_WRITE;
            cls_next  = CLS_PRIVATE;
            done_next = 1'b1;
          end
        end else if ((s inside {ST_SC, ST_SM}) && upd_r) begin
          ns        = shared_r ? ST_SM : ST_M;
          data_next = DATA_WRITE;
          cls_next  = shared_r ? CLS_SHARED : CLS_PRIVATE;
          done_next = 1'b1;
        end else begin
          err_next = 1'b1;
        end
      end
      MODE_SNOOP: begin
        case (s)
          ST_E: begin
            if (upd_r) err_next = 1'b1;
            else       ns = ST_SC;
          end
          ST_SM: begin
            if (upd_r) begin
              ns       = ST_SC;
              clr_next = 1'b1;
            end else begin
              snoop_next = 1'b1;
            end
          end
          ST_M: begin
            if (upd_r) begin
              err_next = 1'b1;
            end else begin
              ns         = ST_SM;
              snoop_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_EVICT: begin
        // evicting an invalid line does nothing
        if (s != ST_I) begin
          ns       = ST_I;
          rel_next = 1'b1;
          wb_next  = (s == ST_M) || (s == ST_SM);
        end
      end
      default: ;
    endcase
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      done_res       <= done_next;
      bus_request    <= bus_next;
      snoop_reply    <= snoop_next;
      data_action    <= data_next;
      allocate       <= alloc_next;
      release_res    <= rel_next;
      clear_dirty    <= clr_next;
      writeback      <= wb_next;
      line_state_out <= ns;
      error          <= err_next;
      access_class   <= cls_next;
      miss           <= miss_next;
    end
  end

endmodule

/* rtl/core/dragon_coherence_controller.sv */
// Dragon update-protocol coherence controller for one private cache. Each event
// (core access, own bus response, snooped transaction, eviction) reads the line's
// state from a NUM_BLOCKS-entry table, decides the new state and the bus, snoop,
// data and bookkeeping actions, writes the state back and delivers one result.
// An event passes from its transfer through index reduction modulo NUM_BLOCKS (a
// reciprocal multiply, then a remainder), a registered table read and a
// decide-and-write step before the next transfer can be taken; one event is worked
// at a time. The result waits in an output register, so a new event is taken while
// the previous result is still stalled. After reset a clearing pass writes every
// table entry invalid, during which in_stall stays high.
// Depends on dcc_pkg, dcc_ctrl and dcc_datapath.
module dragon_coherence_controller import dcc_pkg::*; #(
  parameter int NUM_BLOCKS = DCC_NUM_BLOCKS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [BLK_W-1:0] block_index,
  input  logic             is_store,
  input  logic             bus_kind,
  input  logic             shared_seen,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             done_res,
  output logic [1:0]       bus_request,
  output logic             snoop_reply,
  output logic [1:0]       data_action,
  output logic             allocate,
  output logic             release_res,
  output logic             clear_dirty,
  output logic             writeback,
  output logic [2:0]       line_state_out,
  output logic             error,
  output logic [1:0]       access_class,
  output logic             miss
);

  dcc_cmd_t    cmd;
  dcc_status_t status;

  dcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dcc_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .mode           (mode),
    .block_index    (block_index),
    .is_store       (is_store),
    .bus_kind       (bus_kind),
    .shared_seen    (shared_seen),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .done_res       (done_res),
    .bus_request    (bus_request),
    .snoop_reply    (snoop_reply),
    .data_action    (data_action),
    .allocate       (allocate),
    .release_res    (release_res),
    .clear_dirty    (clear_dirty),
    .writeback      (writeback),
    .line_state_out (line_state_out),
    .error          (error),
    .access_class   (access_class),
    .miss           (miss)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Dragon coherence controller: directed protocol walk,
// then steered random events, each result checked against a line-state predictor or a literal.
// Depends on dcc_pkg and dragon_coherence_controller.
module tb_top;
  import dcc_pkg::*;

  localparam int TB_BLOCKS   = DCC_NUM_BLOCKS;
  localparam int RAND_ITEMS  = 1500;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int HOT_COUNT   = 12;
  localparam int DRAIN_LIMIT = 4000;
  localparam int SETTLE_CYC  = 20;

  // One input event and one result, at the block's field widths
  typedef struct packed {
    mode_t            md;
    logic [BLK_W-1:0] idx;
    logic             st;
    bus_kind_t        kind;
    logic             sh;
  } coh_item_t;

  typedef struct packed {
    logic        done;
    bus_req_t    bus;
    logic        snoop;
    data_act_t   data;
    logic        alloc;
    logic        rel;
    logic        clr;
    logic        wb;
    line_state_t lst;
    logic        err;
    access_cls_t cls;
    logic        miss;
  } coh_result_t;

  typedef struct packed {
    coh_item_t   it;
    logic        has_lit;
    coh_result_t lit;
  } dir_row_t;

  localparam coh_result_t NO_LIT = '0;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [1:0]       mode        = '0;
  logic [BLK_W-1:0] block_index = '0;
  logic             is_store    = 1'b0;
  logic             bus_kind    = 1'b0;
  logic             shared_seen = 1'b0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic             done_res;
  logic [1:0]       bus_request;
  logic             snoop_reply;
  logic [1:0]       data_action;
  logic             allocate;
  logic             release_res;
  logic             clear_dirty;
  logic             writeback;
  logic [2:0]       line_state_out;
  logic             error;
  logic [1:0]       access_class;
  logic             miss;

  line_state_t      shadow_state [TB_BLOCKS];
  coh_result_t      exp_q [$];
  dir_row_t         dir_tab [$];
  logic [BLK_W-1:0] hot_blocks [HOT_COUNT];
  int               fail_cnt = 0;
  logic             calm     = 1'b0;
  logic             hold_req = 1'b0;

  always #2 clk = ~clk;

  dragon_coherence_controller #(.NUM_BLOCKS(TB_BLOCKS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .block_index(block_index), .is_store(is_store),
    .bus_kind(bus_kind), .shared_seen(shared_seen),
    .out_valid(out_valid), .out_stall(out_stall),
    .done_res(done_res), .bus_request(bus_request), .snoop_reply(snoop_reply),
    .data_action(data_action), .allocate(allocate), .release_res(release_res),
    .clear_dirty(clear_dirty), .writeback(writeback),
    .line_state_out(line_state_out), .error(error),
    .access_class(access_class), .miss(miss)
  );

  // Work out the result of one event and advance the shadow line table
  function automatic coh_result_t dragon_next(input coh_item_t it);
    coh_result_t r;
    line_state_t cur;
    line_state_t nxt;
    int unsigned slot;
    slot = it.idx % TB_BLOCKS;
    cur  = shadow_state[slot];
    nxt  = cur;
    r    = '0;
    case (it.md)
      MODE_CORE: begin
        if (cur == ST_I) begin
          r.bus  = REQ_RD;
          r.miss = 1'b1;
        end else if (cur == ST_SC || cur == ST_SM) begin
          if (it.st) begin
            r.bus = REQ_UPD;
          end else begin
            r.data = DATA_READ;
            r.cls  = CLS_SHARED;
            r.done = 1'b1;
          end
        end else begin
          r.data = it.st ? DATA_WRITE : DATA_READ;
          r.cls  = CLS_PRIVATE;
          r.done = 1'b1;
          if (it.st) nxt = ST_M;
        end
      end
      MODE_RESP: begin
        if (cur == ST_I && it.kind == BUS_RD) begin
          r.alloc = 1'b1;
          if (!it.st) begin
            nxt    = it.sh ? ST_SC : ST_E;
            r.data = DATA_READ;
            r.cls  = it.sh ? CLS_SHARED : CLS_PRIVATE;
            r.done = 1'b1;
          end else if (it.sh) begin
            nxt    = ST_SC;
            r.data = DATA_READ;
            r.bus  = REQ_UPD;
          end else begin
            nxt    = ST_M;
            r.data = DATA_WRITE;
            r.cls  = CLS_PRIVATE;
            r.done = 1'b1;
          end
        end else if ((cur == ST_SC || cur == ST_SM) && it.kind == BUS_UPD) begin
          nxt    = it.sh ? ST_SM : ST_M;
          r.data = DATA_WRITE;
          r.cls  = it.sh ? CLS_SHARED : CLS_PRIVATE;
          r.done = 1'b1;
        end else begin
          r.err = 1'b1;
        end
      end
      MODE_SNOOP: begin
        case (cur)
          ST_E: begin
            if (it.kind == BUS_UPD) r.err = 1'b1;
            else nxt = ST_SC;
          end
          ST_SM: begin
            if (it.kind == BUS_UPD) begin
              nxt   = ST_SC;
              r.clr = 1'b1;
            end else begin
              r.snoop = 1'b1;
            end
          end
          ST_M: begin
            if (it.kind == BUS_UPD) begin
              r.err = 1'b1;
            end else begin
              nxt     = ST_SM;
              r.snoop = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: begin
        // eviction of a valid line; an invalid one is left alone
        if (cur != ST_I) begin
          nxt   = ST_I;
          r.rel = 1'b1;
          r.wb  = (cur == ST_M || cur == ST_SM);
        end
      end
    endcase
    shadow_state[slot] = nxt;
    r.lst = nxt;
    return r;
  endfunction

  function automatic coh_item_t evt(input mode_t md, input int idx, input logic st,
                                    input bus_kind_t kind, input logic sh);
    coh_item_t it;
    it.md   = md;
    it.idx  = idx[BLK_W-1:0];
    it.st   = st;
    it.kind = kind;
    it.sh   = sh;
    return it;
  endfunction

  function automatic coh_result_t mk_res(
      input logic done, input bus_req_t bus, input logic snoop, input data_act_t data,
      input logic alloc, input logic rel, input logic clr, input logic wb,
      input line_state_t lst, input logic err, input access_cls_t cls, input logic mis);
    coh_result_t r;
    r = '{done, bus, snoop, data, alloc, rel, clr, wb, lst, err, cls, mis};
    return r;
  endfunction

  task automatic add_row(input coh_item_t it, input logic has_lit, input coh_result_t lit);
    dir_row_t row;
    row.it      = it;
    row.has_lit = has_lit;
    row.lit     = lit;
    dir_tab.push_back(row);
  endtask

  // Pick an event, mostly one the protocol allows for the line's current state
  function automatic coh_item_t pick_item();
    coh_item_t   it;
    line_state_t cur;
    int unsigned dice;
    it.md   = mode_t'($urandom_range(0, 3));
    it.idx  = ($urandom_range(0, 4) == 0) ? BLK_W'($urandom_range(0, TB_BLOCKS - 1))
                                          : hot_blocks[$urandom_range(0, HOT_COUNT - 1)];
    it.st   = 1'($urandom_range(0, 1));
    it.kind = bus_kind_t'($urandom_range(0, 1));
    it.sh   = 1'($urandom_range(0, 1));
    cur     = shadow_state[it.idx % TB_BLOCKS];
    if ($urandom_range(0, 3) != 0) begin
      dice = $urandom_range(0, 99);
      if (cur == ST_I) begin
        if (dice < 60) begin
          it.md = MODE_CORE;
        end else if (dice < 85) begin
          it.md   = MODE_RESP;
          it.kind = BUS_RD;
        end else if (dice < 95) begin
          it.md = MODE_SNOOP;
        end else begin
          it.md = MODE_EVICT;
        end
      end else begin
        if (dice < 50) it.md = MODE_CORE;
        else if (dice < 80) it.md = MODE_SNOOP;
        else it.md = MODE_EVICT;
        // exclusive owners only ever see reads from other cores
        if (it.md == MODE_SNOOP && (cur == ST_E || cur == ST_M)) it.kind = BUS_RD;
      end
    end
    return it;
  endfunction

  // Offer one event and hold it until the transfer; record its expected result
  task automatic send_item(input coh_item_t it, input int gap, input logic has_lit,
                           input coh_result_t lit, output coh_result_t pred);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode        <= it.md;
    block_index <= it.idx;
    is_store    <= it.st;
    bus_kind    <= it.kind;
    shared_seen <= it.sh;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = dragon_next(it);
    exp_q.push_back(has_lit ? lit : pred);
  endtask

  // Stop offering until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_q.size() != 0);
  endtask

  task automatic note_mismatch(input string fld, input logic [3:0] want,
                               input logic [3:0] got);
    fail_cnt++;
    if (fail_cnt <= 60)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    coh_result_t got;
    coh_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{done_res, bus_req_t'(bus_request), snoop_reply, data_act_t'(data_action),
              allocate, release_res, clear_dirty, writeback,
              line_state_t'(line_state_out), error, access_cls_t'(access_class), miss};
      if (exp_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = exp_q.pop_front();
        if (got.done  !== want.done)  note_mismatch("done_res", want.done, got.done);
        if (got.bus   !== want.bus)   note_mismatch("bus_request", want.bus, got.bus);
        if (got.snoop !== want.snoop) note_mismatch("snoop_reply", want.snoop, got.snoop);
        if (got.data  !== want.data)  note_mismatch("data_action", want.data, got.data);
        if (got.alloc !== want.alloc) note_mismatch("allocate", want.alloc, got.alloc);
        if (got.rel   !== want.rel)   note_mismatch("release_res", want.rel, got.rel);
        if (got.clr   !== want.clr)   note_mismatch("clear_dirty", want.clr, got.clr);
        if (got.wb    !== want.wb)    note_mismatch("writeback", want.wb, got.wb);
        if (got.lst   !== want.lst)   note_mismatch("line_state_out", want.lst, got.lst);
        if (got.err   !== want.err)   note_mismatch("error", want.err, got.err);
        if (got.cls   !== want.cls)   note_mismatch("access_class", want.cls, got.cls);
        if (got.miss  !== want.miss)  note_mismatch("miss", want.miss, got.miss);
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none when calm
  initial begin : result_sink
    int unsigned idle_left;
    int unsigned cyc;
    int unsigned rx_pct;
    idle_left = 0;
    cyc       = 0;
    rx_pct    = 20;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_pct = 0;
          1:       rx_pct = 10;
          default: rx_pct = 35;
        endcase
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left > 0) begin
        idle_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
        idle_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed protocol walk, then steered random traffic
  initial begin : stim_main
    coh_item_t   it;
    coh_item_t   pend_it;
    coh_result_t pred;
    logic        pend_ok;
    int          tx_pct;
    int          gap;
    int          k;

    foreach (shadow_state[i]) shadow_state[i] = ST_I;
    hot_blocks[0] = '0;
    hot_blocks[1] = '1;
    for (k = 2; k < HOT_COUNT; k++) hot_blocks[k] = BLK_W'($urandom_range(0, TB_BLOCKS - 1));

    // full protocol walk on block 0
    add_row(evt(MODE_CORE, 0, 0, BUS_RD, 0), 1'b1,
            mk_res(0, REQ_RD, 0, DATA_NONE, 0, 0, 0, 0, ST_I, 0, CLS_NONE, 1));
    add_row(evt(MODE_RESP,  0, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_CORE,  0, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_CORE,  0, 1, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_SNOOP, 0, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_CORE,  0, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_SNOOP, 0, 0, BUS_UPD, 0), 1'b0, NO_LIT);
    add_row(evt(MODE_CORE,  0, 1, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_RESP,  0, 1, BUS_UPD, 1), 1'b0, NO_LIT);
    add_row(evt(MODE_EVICT, 0, 1, BUS_UPD, 1), 1'b0, NO_LIT);
    // evicting an invalid line does nothing
    add_row(evt(MODE_EVICT, 0, 1, BUS_UPD, 1), 1'b1,
            mk_res(0, REQ_NONE, 0, DATA_NONE, 0, 0, 0, 0, ST_I, 0, CLS_NONE, 0));
    // update response on an invalid line is an error
    add_row(evt(MODE_RESP, 1023, 1, BUS_UPD, 1), 1'b1,
            mk_res(0, REQ_NONE, 0, DATA_NONE, 0, 0, 0, 0, ST_I, 1, CLS_NONE, 0));
    add_row(evt(MODE_CORE,  1023, 1, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_RESP,  1023, 1, BUS_RD,  1), 1'b0, NO_LIT);
    add_row(evt(MODE_RESP,  1023, 1, BUS_UPD, 0), 1'b0, NO_LIT);
    // snooped update while modified cannot happen
    add_row(evt(MODE_SNOOP, 1023, 1, BUS_UPD, 1), 1'b1,
            mk_res(0, REQ_NONE, 0, DATA_NONE, 0, 0, 0, 0, ST_M, 1, CLS_NONE, 0));
    add_row(evt(MODE_RESP,  1023, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_EVICT, 1023, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_RESP,  341, 0, BUS_RD,  1), 1'b0, NO_LIT);
    add_row(evt(MODE_SNOOP, 341, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_EVICT, 341, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_RESP,  682, 0, BUS_RD,  0), 1'b0, NO_LIT);
    // snooped update while exclusive cannot happen
    add_row(evt(MODE_SNOOP, 682, 0, BUS_UPD, 0), 1'b1,
            mk_res(0, REQ_NONE, 0, DATA_NONE, 0, 0, 0, 0, ST_E, 1, CLS_NONE, 0));
    add_row(evt(MODE_SNOOP, 682, 0, BUS_RD,  0), 1'b0, NO_LIT);
    add_row(evt(MODE_RESP,  512, 1, BUS_RD,  0), 1'b0, NO_LIT);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      gap = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 11) : 0;
      send_item(dir_tab[i].it, gap, dir_tab[i].has_lit, dir_tab[i].lit, pred);
    end
    wait_drained();

    pend_ok = 1'b0;
    tx_pct  = 20;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_pct = 0;
          1:       tx_pct = 15;
          default: tx_pct = 40;
        endcase
      end
      if (k == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      // let results back up until the input side stalls
      if (k == 400) hold_req = 1'b1;
      if (k == 800) wait_drained();
      // follow an issued bus request with its response most of the time
      if (pend_ok && $urandom_range(0, 99) < 75) begin
        it = pend_it;
      end else begin
        it = pick_item();
      end
      pend_ok = 1'b0;
      gap = (!calm && $urandom_range(0, 99) < tx_pct) ? $urandom_range(1, 11) : 0;
      send_item(it, gap, 1'b0, NO_LIT, pred);
      if (pred.bus != REQ_NONE) begin
        pend_ok      = 1'b1;
        pend_it      = it;
        pend_it.md   = MODE_RESP;
        pend_it.kind = (pred.bus == REQ_RD) ? BUS_RD : BUS_UPD;
        pend_it.sh   = 1'($urandom_range(0, 1));
      end
    end

    in_valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && exp_q.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (exp_q.size() != 0) begin
      fail_cnt++;
      $display("%0t: results missing, expected %0d more, actual 0", $time, exp_q.size());
    end
    if (fail_cnt == 0) begin
      $display("dragon_coherence_controller test passed");
    end else begin
      $display("dragon_coherence_controller test failed");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin : watchdog
    #2_000_000;
    $display("dragon_coherence_controller test failed");
    $finish;
  end

endmodule
